### hdl/mmcs_pkg.sv
// ----------------------------------------------------------------------------
// mmcs_pkg: shared types and constants for the min/max contrast stretch
// widths, register indexes, controller states and the command/status bundles
// ----------------------------------------------------------------------------
package mmcs_pkg;

    localparam int BYTE_W       = 8;
    localparam int PIXEL_BYTES  = 3;
    localparam int DATA_W       = PIXEL_BYTES * BYTE_W;
    localparam int DEF_CHANNELS = 3;
    localparam int MAX_ACTIVE   = PIXEL_BYTES;

    // signed (v - low) and (high - low) spans, and their product
    localparam int SPAN_W = BYTE_W + 1;
    localparam int NUM_W  = 2 * BYTE_W + 1;
    localparam int QUO_W  = 2 * BYTE_W;
    localparam int CNT_W  = $clog2(QUO_W);
    localparam int CH_W   = 2;

    localparam int CFG_IDX_W  = 1;
    localparam int USER_IN_W  = 2;
    localparam int USER_OUT_W = 1;

    localparam int USER_OP_BIT   = 0;
    localparam int USER_FS_BIT   = 1;
    localparam int USER_FLAT_BIT = 0;

    localparam logic OP_STATS = 1'b0;
    localparam logic OP_APPLY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HIGH = 1'b1;

    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_MIN = 8'h00;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_FIX,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic            stats_upd;
        logic            stats_restart;
        logic            apply_load;
        logic            mul;
        logic            div_load;
        logic            div_step;
        logic            fix;
        logic            emit;
        logic [CH_W-1:0] ch;
    } t_mmcs_cmd;

    typedef struct packed {
        logic flat;
    } t_mmcs_sts;

endpackage

### hdl/mmcs_ctrl.sv
// ----------------------------------------------------------------------------
// mmcs_ctrl: sequencing state machine
// walks each active channel through multiply, divide and fix-up steps
// ----------------------------------------------------------------------------
module mmcs_ctrl
    import mmcs_pkg::*;
#(
    parameter int ACTIVE = MAX_ACTIVE
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_op,
    input  logic      i_in_restart,
    input  logic      i_out_ready,
    input  t_mmcs_sts i_sts,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_mmcs_cmd o_cmd
);

    localparam logic [CH_W-1:0]  LAST_CH  = CH_W'(ACTIVE - 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(QUO_W - 1);

    t_state             r_state, n_state;
    logic [CH_W-1:0]    r_ch, n_ch;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    logic               emit_ok;

    // output slot free this cycle
    assign emit_ok = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_in_op == OP_APPLY) n_state = ST_CHECK;
            end
            ST_CHECK: n_state = i_sts.flat ? ST_EMIT : ST_MUL;
            ST_MUL:   n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == LAST_CNT) n_state = ST_FIX;
            end
            ST_FIX:   n_state = (r_ch == LAST_CH) ? ST_EMIT : ST_MUL;
            ST_EMIT: begin
                if (emit_ok) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_ch  = r_ch;
        n_cnt = r_cnt;
        if (r_state == ST_CHECK) n_ch = '0;
        if (r_state == ST_FIX && r_ch != LAST_CH) n_ch = r_ch + 1'b1;
        if (r_state == ST_LOAD) n_cnt = '0;
        if (r_state == ST_DIV) n_cnt = r_cnt + 1'b1;
    end

    always_comb begin
        o_cmd               = '0;
        o_cmd.ch            = r_ch;
        o_cmd.stats_restart = i_in_restart;
        o_in_ready          = (r_state == ST_IDLE);
        o_cmd.stats_upd     = (r_state == ST_IDLE) && i_in_valid && (i_in_op == OP_STATS);
        o_cmd.apply_load    = (r_state == ST_IDLE) && i_in_valid && (i_in_op == OP_APPLY);
        o_cmd.mul           = (r_state == ST_MUL);
        o_cmd.div_load      = (r_state == ST_LOAD);
        o_cmd.div_step      = (r_state == ST_DIV);
        o_cmd.fix           = (r_state == ST_FIX);
        o_cmd.emit          = (r_state == ST_EMIT) && emit_ok;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) n_out_valid = 1'b0;
        if (o_cmd.emit) n_out_valid = 1'b1;
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ch        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### hdl/mmcs_dp.sv
// ----------------------------------------------------------------------------
// mmcs_dp: statistics, target registers, multiplier and radix-2 divider
// holds per-channel min/max and builds the stretched pixel one channel at a time
// ----------------------------------------------------------------------------
module mmcs_dp
    import mmcs_pkg::*;
#(
    parameter int ACTIVE = MAX_ACTIVE
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  t_mmcs_cmd                              i_cmd,
    input  logic                                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                   i_cfg_idx,
    input  logic [BYTE_W-1:0]                      i_cfg_data,
    input  logic [PIXEL_BYTES-1:0][BYTE_W-1:0]     i_px,
    output t_mmcs_sts                              o_sts,
    output logic [PIXEL_BYTES-1:0][BYTE_W-1:0]     o_px,
    output logic                                   o_flat
);

    logic [BYTE_W-1:0]                    r_tlow, r_thigh;
    logic [ACTIVE-1:0][BYTE_W-1:0]        r_low, r_high, n_low, n_high;
    logic [ACTIVE-1:0][BYTE_W-1:0]        base_low, base_high;
    logic [PIXEL_BYTES-1:0][BYTE_W-1:0]   r_px, r_res, r_opx;
    logic                                 r_flat, r_oflat, flat_now;

    logic [BYTE_W-1:0]                    sel_low, sel_high;
    logic signed [SPAN_W-1:0]             diff, scale, span;
    logic signed [2*SPAN_W-1:0]           prod;
    logic signed [NUM_W-1:0]              r_num, num_mag;
    logic signed [SPAN_W-1:0]             r_span, span_mag;

    logic [BYTE_W-1:0]                    r_rem, n_rem, r_dvs;
    logic [QUO_W-1:0]                     r_quo, quo_s;
    logic [BYTE_W:0]                      trial, trial_sub;
    logic                                 r_neg, ge;

    // target range registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlow  <= BYTE_MIN;
            r_thigh <= BYTE_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TARGET_LOW:  r_tlow  <= i_cfg_data;
                REG_TARGET_HIGH: r_thigh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // running min/max, restart folds into the same update
    always_comb begin
        for (int c = 0; c < ACTIVE; c++) begin
            base_low[c]  = i_cmd.stats_restart ? BYTE_MAX : r_low[c];
            base_high[c] = i_cmd.stats_restart ? BYTE_MIN : r_high[c];
            n_low[c]     = (i_px[c] < base_low[c])  ? i_px[c] : base_low[c];
            n_high[c]    = (i_px[c] > base_high[c]) ? i_px[c] : base_high[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= {ACTIVE{BYTE_MAX}};
            r_high <= {ACTIVE{BYTE_MIN}};
        end else if (i_cmd.stats_upd) begin
            r_low  <= n_low;
            r_high <= n_high;
        end
    end

    always_comb begin
        flat_now = 1'b0;
        sel_low  = r_low[0];
        sel_high = r_high[0];
        for (int c = 0; c < ACTIVE; c++) begin
            if (r_low[c] == r_high[c]) flat_now = 1'b1;
            if (i_cmd.ch == CH_W'(c)) begin
                sel_low  = r_low[c];
                sel_high = r_high[c];
            end
        end
    end

    // (v - low) * (thigh - tlow) and high - low
    assign diff  = $signed({1'b0, r_px[i_cmd.ch]}) - $signed({1'b0, sel_low});
    assign scale = $signed({1'b0, r_thigh}) - $signed({1'b0, r_tlow});
    assign span  = $signed({1'b0, sel_high}) - $signed({1'b0, sel_low});
    assign prod  = diff * scale;

    assign num_mag  = r_num[NUM_W-1]   ? -r_num  : r_num;
    assign span_mag = r_span[SPAN_W-1] ? -r_span : r_span;

    // restoring divide step
    assign trial     = {r_rem, r_quo[QUO_W-1]};
    assign ge        = (trial >= {1'b0, r_dvs});
    assign trial_sub = trial - {1'b0, r_dvs};
    assign n_rem     = ge ? trial_sub[BYTE_W-1:0] : trial[BYTE_W-1:0];

    // truncation toward zero: divide magnitudes, then restore sign
    assign quo_s = r_neg ? -r_quo : r_quo;

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply_load) begin
            r_px   <= i_px;
            r_res  <= i_px;
            r_flat <= flat_now;
        end
        if (i_cmd.mul) begin
            r_num  <= prod[NUM_W-1:0];
            r_span <= span;
        end
        if (i_cmd.div_load) begin
            r_quo <= num_mag[QUO_W-1:0];
            r_dvs <= span_mag[BYTE_W-1:0];
            r_rem <= '0;
            r_neg <= r_num[NUM_W-1] ^ r_span[SPAN_W-1];
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
        if (i_cmd.fix) begin
            r_res[i_cmd.ch] <= quo_s[BYTE_W-1:0] + r_tlow;
        end
        if (i_cmd.emit) begin
            r_opx   <= r_res;
            r_oflat <= r_flat;
        end
    end

    assign o_sts.flat = r_flat;
    assign o_px       = r_opx;
    assign o_flat     = r_oflat;

endmodule

### hdl/rgb_min_max_contrast_stretch_top.sv
// ----------------------------------------------------------------------------
// rgb_min_max_contrast_stretch_top: per-channel rgb min/max contrast stretch
// gathers channel min/max, then maps pixels into the target output range
// ----------------------------------------------------------------------------
// usage:
//   slave stream carries one pixel per word: tdata = red, green, blue bytes,
//   tuser = op (gather/apply) and frame start. a gather word updates the kept
//   per-channel min/max in the cycle it is accepted (one word per cycle).
//   an apply word produces one master word: stretched bytes in tdata and the
//   flat flag in tuser; a flat channel passes the pixel unchanged. the user
//   must write target_low/target_high on the cfg port while idle (not enforced).
// sequencing:
//   a flat apply goes straight to emit; else each active channel in turn
//   passes a multiply step, a load step, the shared 16-step restoring divider
//   and a fix-up step. no new word is accepted until the result is emitted.
// reset: synchronous, active low; min resets to 255, max to 0, targets 0/255.
// stall: the result sits in an output register; the next word is accepted
//   while it waits, and a later apply word holds in the emit step until taken.
// ----------------------------------------------------------------------------
module rgb_min_max_contrast_stretch_top
    import mmcs_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [DATA_W-1:0]      i_s_axis_tdata,   // red_in, green_in, blue_in
    input  logic [USER_IN_W-1:0]   i_s_axis_tuser,   // op, frame_start
    // master side
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [DATA_W-1:0]      o_m_axis_tdata,   // red_out, green_out, blue_out
    output logic [USER_OUT_W-1:0]  o_m_axis_tuser,   // flat_channel
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [BYTE_W-1:0]      i_cfg_data
);

    // only the red, green and blue channels can be tracked
    localparam int ACTIVE = (CHANNELS < MAX_ACTIVE) ? CHANNELS : MAX_ACTIVE;

    t_mmcs_cmd                          cmd;
    t_mmcs_sts                          sts;
    logic [PIXEL_BYTES-1:0][BYTE_W-1:0] out_px;
    logic                               out_flat;

    mmcs_ctrl #(
        .ACTIVE (ACTIVE)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .i_in_op      (i_s_axis_tuser[USER_OP_BIT]),
        .i_in_restart (i_s_axis_tuser[USER_FS_BIT]),
        .i_out_ready  (i_m_axis_tready),
        .i_sts        (sts),
        .o_in_ready   (o_s_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_cmd        (cmd)
    );

    mmcs_dp #(
        .ACTIVE (ACTIVE)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_px       (i_s_axis_tdata),
        .o_sts      (sts),
        .o_px       (out_px),
        .o_flat     (out_flat)
    );

    assign o_m_axis_tdata                = out_px;
    assign o_m_axis_tuser[USER_FLAT_BIT] = out_flat;

`ifndef NO_ASSERTIONS
    // a gather word leaves the controller in idle, so the slave side stays open
    a_gather_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser[USER_OP_BIT] == OP_STATS)
        |=> o_s_axis_tready)
        else $error("slave side closed after a gather word");

    // an apply word occupies the datapath, so the slave side closes
    a_apply_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser[USER_OP_BIT] == OP_APPLY)
        |=> !o_s_axis_tready)
        else $error("slave side still open after an apply word");

    // a result only appears out of the emit step, never straight from idle
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result word raised while the block was idle");
`endif

endmodule

### sim/rgb_min_max_contrast_stretch_top_tb.sv
// ----------------------------------------------------------------------------
// rgb_min_max_contrast_stretch_top_tb: self-checking bench for the rgb stretch
// a directed table and then random frames run through the pixel stream. a
// built-in stretch predictor works out every apply word, and each output word
// is checked field by field. both stream sides idle at random, and the target
// range is rewritten between phases, extremes and a reversed range among them
// ----------------------------------------------------------------------------
module rgb_min_max_contrast_stretch_top_tb
    import mmcs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 12;
    // time for the block to return to idle after the last word is taken
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 500_000;
    localparam int PHASE_ITEMS   = 108;
    localparam int N_PHASES      = 8;
    localparam int N_FIXED       = 6;
    localparam int MAX_REPORTS   = 10;
    localparam int ACTIVE = (DEF_CHANNELS < PIXEL_BYTES) ? DEF_CHANNELS : PIXEL_BYTES;

    // one expected output word
    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic              flat;
    } t_stretched;

    // one row of the directed table; the result is typed in only when known
    typedef struct packed {
        logic              op;
        logic              fs;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic              typed;
        logic [BYTE_W-1:0] exp_red;
        logic [BYTE_W-1:0] exp_green;
        logic [BYTE_W-1:0] exp_blue;
        logic              exp_flat;
    } t_dir_row;

    localparam t_dir_row DIRECTED [21] = '{
        //  op        fs    red     green   blue     typed expected r/g/b        flat
        // apply before any gather: inverted range, full 255 scale
        '{OP_APPLY, 1'b0, 8'd0,   8'd128, 8'd255,  1'b1, 8'd255, 8'd127, 8'd0,   1'b0},
        // full 0..255 range gives the identity map
        '{OP_STATS, 1'b1, 8'd0,   8'd0,   8'd0,    1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{OP_STATS, 1'b0, 8'd255, 8'd255, 8'd255,  1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{OP_APPLY, 1'b0, 8'd0,   8'd128, 8'd255,  1'b1, 8'd0,   8'd128, 8'd255, 1'b0},
        '{OP_APPLY, 1'b0, 8'd255, 8'd1,   8'd77,   1'b1, 8'd255, 8'd1,   8'd77,  1'b0},
        // single gathered pixel: every channel flat, pixel passes unchanged
        '{OP_STATS, 1'b1, 8'd10,  8'd20,  8'd30,   1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{OP_APPLY, 1'b0, 8'd1,   8'd2,   8'd3,    1'b1, 8'd1,   8'd2,   8'd3,   1'b1},
        // frame start on an apply word is ignored
        '{OP_APPLY, 1'b1, 8'd200, 8'd100, 8'd50,   1'b1, 8'd200, 8'd100, 8'd50,  1'b1},
        // only green still flat
        '{OP_STATS, 1'b0, 8'd50,  8'd20,  8'd40,   1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{OP_APPLY, 1'b0, 8'd7,   8'd8,   8'd9,    1'b1, 8'd7,   8'd8,   8'd9,   1'b1},
        // all ranges open, values inside and outside them
        '{OP_STATS, 1'b0, 8'd50,  8'd60,  8'd40,   1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{OP_APPLY, 1'b0, 8'd30,  8'd40,  8'd35,   1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{OP_APPLY, 1'b0, 8'd0,   8'd0,   8'd0,    1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{OP_APPLY, 1'b0, 8'd255, 8'd255, 8'd255,  1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{OP_STATS, 1'b1, 8'd255, 8'd0,   8'd128,  1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{OP_STATS, 1'b0, 8'd0,   8'd255, 8'd129,  1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{OP_APPLY, 1'b1, 8'd128, 8'd128, 8'd128,  1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        // flat at the top and at the bottom of the byte range
        '{OP_STATS, 1'b1, 8'd255, 8'd255, 8'd255,  1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{OP_APPLY, 1'b0, 8'd0,   8'd255, 8'd170,  1'b1, 8'd0,   8'd255, 8'd170, 1'b1},
        '{OP_STATS, 1'b1, 8'd0,   8'd0,   8'd0,    1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
        '{OP_APPLY, 1'b0, 8'd85,  8'd170, 8'd255,  1'b1, 8'd85,  8'd170, 8'd255, 1'b1}
    };

    // target settings of the fixed phases: reset, reversed, both extremes
    // collapsed, a video range and a one-step reversal
    localparam int PHASE_LOW  [N_FIXED] = '{0, 255, 0, 255, 16, 128};
    localparam int PHASE_HIGH [N_FIXED] = '{255, 0, 0, 255, 235, 127};

    logic                  i_clk    = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [DATA_W-1:0]     s_tdata  = '0;
    logic [USER_IN_W-1:0]  s_tuser  = '0;
    logic                  m_tready = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [BYTE_W-1:0]     cfg_data = '0;

    wire                   s_tready;
    wire                   m_tvalid;
    wire [DATA_W-1:0]      m_tdata;     // red_out, green_out, blue_out
    wire [USER_OUT_W-1:0]  m_tuser;     // flat_channel

    // predictor state: kept channel min/max and the target range
    logic [BYTE_W-1:0] stat_low  [PIXEL_BYTES];
    logic [BYTE_W-1:0] stat_high [PIXEL_BYTES];
    logic [BYTE_W-1:0] tgt_low  = 8'd0;
    logic [BYTE_W-1:0] tgt_high = 8'd255;

    t_stretched stretched_q [$];

    int  items_sent  = 0;
    int  words_taken = 0;
    int  words_paced = 0;
    int  stall_left  = 0;
    int  mismatches  = 0;
    int  cycles      = 0;
    bit  s_quiet     = 1'b1;
    bit  r_quiet     = 1'b1;

    rgb_min_max_contrast_stretch_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // stretch predictor
    // ------------------------------------------------------------------

    // frame start: min back to 255, max back to 0
    function automatic void clear_stats();
        for (int c = 0; c < PIXEL_BYTES; c++) begin
            stat_low[c]  = BYTE_MAX;
            stat_high[c] = BYTE_MIN;
        end
    endfunction

    // signed math, division truncates toward zero, sum wraps to a byte
    function automatic logic [BYTE_W-1:0] stretch_level(logic [BYTE_W-1:0] v, int c);
        int span;
        int scale;
        int num;
        int q;
        span  = int'(stat_high[c]) - int'(stat_low[c]);
        scale = int'(tgt_high) - int'(tgt_low);
        num   = (int'(v) - int'(stat_low[c])) * scale;
        if (span == 0)
            return v;
        q = num / span + int'(tgt_low);
        return q[BYTE_W-1:0];
    endfunction

    // an accepted word either updates the kept min/max or queues its result
    function automatic void absorb_pixel(logic op, logic fs, logic [BYTE_W-1:0] red,
                                         logic [BYTE_W-1:0] green, logic [BYTE_W-1:0] blue,
                                         bit typed, t_stretched typed_word);
        logic [BYTE_W-1:0] px  [PIXEL_BYTES];
        logic [BYTE_W-1:0] res [PIXEL_BYTES];
        bit                flat;
        t_stretched        word;
        px = '{red, green, blue};
        if (op == OP_STATS) begin
            if (fs)
                clear_stats();
            for (int c = 0; c < ACTIVE; c++) begin
                if (px[c] < stat_low[c])
                    stat_low[c] = px[c];
                if (px[c] > stat_high[c])
                    stat_high[c] = px[c];
            end
            return;
        end
        flat = 1'b0;
        for (int c = 0; c < ACTIVE; c++)
            if (stat_high[c] == stat_low[c])
                flat = 1'b1;
        res = px;
        if (!flat)
            for (int c = 0; c < ACTIVE; c++)
                res[c] = stretch_level(px[c], c);
        word.red   = res[0];
        word.green = res[1];
        word.blue  = res[2];
        word.flat  = flat;
        stretched_q.push_back(typed ? typed_word : word);
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, 7);
    endfunction

    // random byte, leaning on the two extremes
    function automatic logic [BYTE_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return BYTE_MIN;
            1:       return BYTE_MAX;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // drive one pixel word and hold it until the block takes it
    task automatic send_word(logic op, logic fs, logic [BYTE_W-1:0] red,
                             logic [BYTE_W-1:0] green, logic [BYTE_W-1:0] blue,
                             bit typed = 1'b0, t_stretched typed_word = '0);
        int                   gap;
        logic [USER_IN_W-1:0] user;
        gap = draw_gap(s_quiet);
        user = '0;
        user[USER_OP_BIT] = op;
        user[USER_FS_BIT] = fs;
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {blue, green, red};
        s_tuser  <= user;
        do
            @(posedge i_clk);
        while (!s_tready);
        absorb_pixel(op, fs, red, green, blue, typed, typed_word);
        items_sent++;
    endtask

    // drop valid, wait for every queued word, then let the block settle
    task automatic wait_idle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (stretched_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_target(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == REG_TARGET_LOW)
            tgt_low = val;
        else
            tgt_high = val;
    endtask

    // random frames: mostly gather-then-apply frames, some with narrow or
    // flat channels, and loose words with random op and frame start
    task automatic run_phase(int quota);
        int                start;
        int                kind;
        int                n_gather;
        int                n_apply;
        logic [BYTE_W-1:0] base [PIXEL_BYTES];
        int                win  [PIXEL_BYTES];
        start = items_sent;
        while (items_sent - start < quota) begin
            kind = $urandom_range(0, 19);
            if (kind < 17) begin
                n_gather = $urandom_range(1, 12);
                n_apply  = $urandom_range(1, 10);
                for (int c = 0; c < PIXEL_BYTES; c++) begin
                    // narrow frames keep each channel in a small window
                    win[c]  = (kind < 13) ? 255 : $urandom_range(0, 3);
                    base[c] = BYTE_W'($urandom_range(0, 255 - win[c]));
                end
                for (int i = 0; i < n_gather; i++) begin
                    if (kind < 13)
                        send_word(OP_STATS, i == 0, pick_level(), pick_level(), pick_level());
                    else
                        send_word(OP_STATS, i == 0,
                                  base[0] + BYTE_W'($urandom_range(0, win[0])),
                                  base[1] + BYTE_W'($urandom_range(0, win[1])),
                                  base[2] + BYTE_W'($urandom_range(0, win[2])));
                end
                for (int i = 0; i < n_apply; i++)
                    send_word(OP_APPLY, $urandom_range(0, 3) == 0,
                              pick_level(), pick_level(), pick_level());
            end else begin
                send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          pick_level(), pick_level(), pick_level());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // output side: random stall after every word, checker on every word
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (words_taken != words_paced) begin
            words_paced = words_taken;
            stall_left  = draw_gap(r_quiet);
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_stretched want;
        if (rst_n && m_tvalid && m_tready) begin
            words_taken++;
            if (stretched_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("output word %0d with nothing expected: tdata %h tuser %b",
                             words_taken, m_tdata, m_tuser);
            end else begin
                want = stretched_q.pop_front();
                if (m_tdata[0*BYTE_W +: BYTE_W] !== want.red   ||
                    m_tdata[1*BYTE_W +: BYTE_W] !== want.green ||
                    m_tdata[2*BYTE_W +: BYTE_W] !== want.blue  ||
                    m_tuser[USER_FLAT_BIT]      !== want.flat) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("word %0d: expected r %0d g %0d b %0d flat %0b,",
                                 words_taken, want.red, want.green, want.blue, want.flat,
                                 " got r %0d g %0d b %0d flat %0b",
                                 m_tdata[0*BYTE_W +: BYTE_W], m_tdata[1*BYTE_W +: BYTE_W],
                                 m_tdata[2*BYTE_W +: BYTE_W], m_tuser[USER_FLAT_BIT]);
                end
            end
        end
    end

    // hang guard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** rgb_min_max_contrast_stretch_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        t_dir_row   row;
        t_stretched row_word;
        int         lo;
        int         hi;
        clear_stats();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // directed table at the reset targets, no idling
        foreach (DIRECTED[k]) begin
            row = DIRECTED[k];
            row_word.red   = row.exp_red;
            row_word.green = row.exp_green;
            row_word.blue  = row.exp_blue;
            row_word.flat  = row.exp_flat;
            send_word(row.op, row.fs, row.red, row.green, row.blue, row.typed, row_word);
        end
        wait_idle();

        // random phases, each with its own target range and idle pattern;
        // the drain before every rewrite also holds the sender until all
        // expected words are out
        for (int p = 0; p < N_PHASES; p++) begin
            if (p < N_FIXED) begin
                lo = PHASE_LOW[p];
                hi = PHASE_HIGH[p];
            end else begin
                lo = $urandom_range(0, 255);
                hi = $urandom_range(0, 255);
            end
            write_target(REG_TARGET_LOW, BYTE_W'(lo));
            write_target(REG_TARGET_HIGH, BYTE_W'(hi));
            s_quiet = (p % 4 == 1);
            r_quiet = (p % 4 == 2);
            run_phase(PHASE_ITEMS);
            wait_idle();
        end

        if (mismatches == 0 && stretched_q.size() == 0)
            $display("** rgb_min_max_contrast_stretch_top: PASSED **");
        else
            $display("** rgb_min_max_contrast_stretch_top: FAILED **");
        $finish;
    end

endmodule
